>>> rtl/cpr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the packet receiver.
// No dependencies; every rtl file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  // receive buffer size in bytes, marker through CRC
  localparam int BUFFER_BYTES = 512;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int HDR_BYTES    = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 112;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOF_BYTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 2'd2;

  localparam logic [7:0]  RST_SOF_BYTE    = 8'd170;
  localparam logic [8:0]  RST_MAX_PAYLOAD = 9'd256;
  localparam logic [15:0] RST_TIMEOUT_MS  = 16'd1000;

  // header byte positions
  localparam logic [1:0] POS_CMD    = 2'd1;
  localparam logic [1:0] POS_LEN_LO = 2'd2;
  localparam logic [1:0] POS_LEN_HI = 2'd3;

  typedef enum logic [2:0] {
    ST_OK  = 3'd0,
    ST_CRC = 3'd1,
    ST_LEN = 3'd2,
    ST_OVF = 3'd3,
    ST_TMO = 3'd4
  } status_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;
    logic [7:0]  command;
    logic [15:0] frame_len;
    status_t     status;
    logic [31:0] good_count;
    logic [31:0] error_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  sof_byte;
    logic [8:0]  max_payload;
    logic [15:0] timeout_ms;
  } cfg_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

endpackage

`default_nettype wire

>>> rtl/crc_checked_packet_receiver_core.sv
// Packet receiver with on-the-fly CRC-16/CCITT-FALSE check.
// Slave stream in_*: in_tuser is func (0 byte, 1 timeout tick), in_tdata carries
//   rx_byte and now_ms. Master stream out_*: out_tuser is kind (0 payload byte,
//   1 verdict), out_tdata carries the byte, index, command, length, status and
//   both frame counters. Frames: marker, command, length LE, payload, CRC LE.
// cfg_we/cfg_index/cfg_wdata write sof_byte, max_payload and timeout_ms;
//   write only while no request is in flight.
// Path: an accepted request sits in the input register, goes through the
//   frame engine and, once the output register can take it, is loaded there;
//   the result is offered to the master stream from the output register.
// Throughput: one request per cycle while the output side does not stall;
//   the byte-wide CRC update and frame decision are combinational between the two registers.
// Requests that produce no result still pass through the engine.
// Stall: while out_tready is low and a result is held, the engine waits and
//   in_tready drops once the input register is full; nothing is lost.
// Reset (rst_n low, synchronous): both stages empty, no frame open, counters
//   zero, CRC 0xFFFF, registers to marker 0xAA, max payload 256, timeout 1000.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_packet_receiver_core
  import cpr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // rx_byte[7:0], now_ms[39:8]
  input  wire logic                   in_tuser,   // func
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // payload_byte[7:0], payload_index[16:8], command[24:17], frame_len[40:25],
  // status[43:41], good_count[75:44], error_count[107:76], zeros[111:108]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser,  // kind
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      can_take;
  logic      fire;
  logic      emit;
  out_item_t result;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SOF_BYTE:    cfg_nxt.sof_byte    = cfg_wdata[7:0];
        REG_MAX_PAYLOAD: cfg_nxt.max_payload = cfg_wdata[8:0];
        REG_TIMEOUT_MS:  cfg_nxt.timeout_ms  = cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sof_byte    <= RST_SOF_BYTE;
      cfg_r.max_payload <= RST_MAX_PAYLOAD;
      cfg_r.timeout_ms  <= RST_TIMEOUT_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign fire = s1_valid && can_take;

  cpr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  cpr_frame_eng u_frame_eng (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item),
    .cfg    (cfg_r),
    .emit   (emit),
    .result (result)
  );

  cpr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && emit),
    .item       (result),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  // engine must never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && emit && out_tvalid && !out_tready))
    else $error("result register overwritten while stalled");

  // payload results always carry ok status
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[43:41] == ST_OK))
    else $error("payload result with non-ok status");

  // a verdict status is one of the defined codes
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[43:41] <= ST_TMO))
    else $error("verdict with undefined status");

  // a held request stays put while the engine waits
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !can_take) |=> (s1_valid && $stable(s1_item)))
    else $error("input register changed while engine stalled");
`endif

endmodule

`default_nettype wire

>>> rtl/cpr_in_stage.sv
// Input register of the packet receiver: unpacks and holds one request.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpr_in_stage
  import cpr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,  // rx_byte, now_ms
  input  wire logic                  in_tuser,  // func
  input  wire logic                  take,
  output logic                       item_valid,
  output in_item_t                   item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // slot frees up in the same cycle the engine consumes it
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b0;
    if (in_tvalid && in_tready) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func    <= in_tuser;
      item_r.rx_byte <= in_tdata[7:0];
      item_r.now_ms  <= in_tdata[39:8];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> rtl/cpr_frame_eng.sv
// Frame engine: header decode, running CRC, payload forwarding, verdicts
// and the good/error counters. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpr_frame_eng
  import cpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output logic          emit,
  output out_item_t     result
);

  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [31:0]      start_r, start_nxt;
  logic [31:0]      good_r, good_nxt;
  logic [31:0]      bad_r, bad_nxt;

  logic             opening;
  logic             timed_out;
  logic [31:0]      age;
  logic [CNT_W-1:0] cnt_eff;
  logic [7:0]       cmd_eff;
  logic [15:0]      len_eff;
  logic [15:0]      crc_eff;
  logic [7:0]       crc_lo_eff;
  logic [CNT_W-1:0] pay_pos;
  logic [15:0]      pos_ext;
  logic [15:0]      crc_step;
  logic             close;
  status_t          status;
  logic             kind;
  logic [7:0]       pbyte;
  logic [8:0]       pidx;

  assign age       = item.now_ms - start_r;
  assign timed_out = in_frame_r && (age > {16'd0, cfg.timeout_ms});
  assign opening   = !in_frame_r && (item.rx_byte == cfg.sof_byte);

  // a marker outside a frame starts from cleared frame state
  assign cnt_eff    = opening ? '0 : cnt_r;
  assign cmd_eff    = opening ? 8'd0 : cmd_r;
  assign len_eff    = opening ? 16'd0 : len_r;
  assign crc_eff    = opening ? CRC_INIT : crc_r;
  assign crc_lo_eff = opening ? 8'd0 : crc_lo_r;

  assign pay_pos  = cnt_eff - CNT_W'(HDR_BYTES);
  assign pos_ext  = {{(16 - CNT_W){1'b0}}, pay_pos};
  assign crc_step = crc16_byte(crc_eff, item.rx_byte);

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    start_nxt    = start_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    close        = 1'b0;
    emit         = 1'b0;
    kind         = 1'b0;
    pbyte        = 8'd0;
    pidx         = 9'd0;
    status       = ST_OK;

    if (item.func) begin
      if (timed_out) begin
        close  = 1'b1;
        status = ST_TMO;
      end
    end else if (in_frame_r || opening) begin
      in_frame_nxt = 1'b1;
      cnt_nxt      = cnt_eff;
      cmd_nxt      = cmd_eff;
      len_nxt      = len_eff;
      crc_nxt      = crc_eff;
      crc_lo_nxt   = crc_lo_eff;
      start_nxt    = opening ? item.now_ms : start_r;
      if (cnt_eff >= CNT_W'(BUFFER_BYTES)) begin
        // byte is dropped, frame closes
        close  = 1'b1;
        status = ST_OVF;
      end else begin
        cnt_nxt = cnt_eff + 1'b1;
        if (cnt_eff < CNT_W'(HDR_BYTES)) begin
          case (cnt_eff[1:0])
            POS_CMD:    cmd_nxt = item.rx_byte;
            POS_LEN_LO: len_nxt = {len_eff[15:8], item.rx_byte};
            POS_LEN_HI: len_nxt = {item.rx_byte, len_eff[7:0]};
            default:    ;
          endcase
          crc_nxt = crc_step;
        end else if (pos_ext < len_eff) begin
          crc_nxt = crc_step;
          emit    = 1'b1;
          pbyte   = item.rx_byte;
          pidx    = pos_ext[8:0];
        end else if (pos_ext == len_eff) begin
          crc_lo_nxt = item.rx_byte;
        end else if (len_eff > {7'd0, cfg.max_payload}) begin
          close  = 1'b1;
          status = ST_LEN;
        end else if (crc_eff == {item.rx_byte, crc_lo_eff}) begin
          close  = 1'b1;
          status = ST_OK;
        end else begin
          close  = 1'b1;
          status = ST_CRC;
        end
      end
    end

    if (close) begin
      in_frame_nxt = 1'b0;
      cnt_nxt      = '0;
      emit         = 1'b1;
      kind         = 1'b1;
      if (status == ST_OK) good_nxt = good_r + 32'd1;
      else                 bad_nxt  = bad_r + 32'd1;
    end
  end

  always_comb begin
    result.kind          = kind;
    result.payload_byte  = pbyte;
    result.payload_index = pidx;
    result.command       = cmd_nxt;
    result.frame_len     = len_nxt;
    result.status        = status;
    result.good_count    = good_nxt;
    result.error_count   = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      cmd_r      <= 8'd0;
      len_r      <= 16'd0;
      crc_r      <= CRC_INIT;
      crc_lo_r   <= 8'd0;
      start_r    <= 32'd0;
      good_r     <= 32'd0;
      bad_r      <= 32'd0;
    end else if (fire) begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
      start_r    <= start_nxt;
      good_r     <= good_nxt;
      bad_r      <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cpr_out_stage.sv
// Output register of the packet receiver: holds one result and packs it
// onto the master-side stream. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpr_out_stage
  import cpr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire out_item_t              item,
  output logic                        can_take,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // payload_byte, payload_index, command, frame_len, status,
  // good_count, error_count, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser  // kind
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign can_take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) valid_nxt = 1'b0;
    if (load)       valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) item_r <= item;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = item_r.kind;
  assign out_tdata  = {4'd0, item_r.error_count, item_r.good_count, item_r.status,
                       item_r.frame_len, item_r.command, item_r.payload_index,
                       item_r.payload_byte};

endmodule

`default_nettype wire

>>> test/cpr_tb_pkg.sv
`timescale 1ns / 1ps
// Bench-side CRC-16/CCITT-FALSE byte step, shared by the stimulus and the checker.
// Depends on cpr_pkg for the CRC constants.
package cpr_tb_pkg;
  import cpr_pkg::*;

  // bit-serial form: feedback is the top CRC bit xor the next data bit, MSB first
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

endpackage

>>> test/cpr_checker.sv
`timescale 1ns / 1ps
// Checker for the packet receiver: follows register writes and accepted requests,
// predicts payload and verdict results, compares them against the result stream.
// Depends on cpr_pkg and cpr_tb_pkg.
module cpr_checker
  import cpr_pkg::*;
  import cpr_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     pending
);

  cfg_t        regs;
  logic        framing;
  int unsigned held;        // bytes of the open frame taken so far
  logic [7:0]  cmd_byte;
  logic [15:0] len_field;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;
  logic [31:0] t_open;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;
  out_item_t   results_due[$];
  out_item_t   want;
  out_item_t   got;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void push_result(input logic kind, input logic [7:0] pbyte,
                                      input logic [8:0] pidx, input status_t st);
    out_item_t r;
    r.kind          = kind;
    r.payload_byte  = pbyte;
    r.payload_index = pidx;
    r.command       = cmd_byte;
    r.frame_len     = len_field;
    r.status        = st;
    r.good_count    = good_frames;
    r.error_count   = bad_frames;
    results_due.push_back(r);
  endfunction

  function automatic void close_frame(input status_t st);
    framing = 1'b0;
    held    = 0;
    if (st == ST_OK) good_frames = good_frames + 32'd1;
    else bad_frames = bad_frames + 32'd1;
    push_result(1'b1, 8'h00, 9'd0, st);
  endfunction

  function automatic void framer_step(input logic tick, input logic [7:0] b,
                                      input logic [31:0] now);
    int unsigned pos;
    logic [31:0] age;
    if (tick) begin
      age = now - t_open;
      if (framing && age > {16'h0000, regs.timeout_ms}) close_frame(ST_TMO);
      return;
    end
    if (!framing) begin
      if (b != regs.sof_byte) return;
      framing   = 1'b1;
      held      = 0;
      cmd_byte  = 8'h00;
      len_field = 16'h0000;
      crc_acc   = CRC_INIT;
      crc_lo    = 8'h00;
      t_open    = now;
    end
    // a full buffer drops the incoming byte, marker or not
    if (held >= BUFFER_BYTES) begin
      close_frame(ST_OVF);
      return;
    end
    pos  = held;
    held = held + 1;
    if (pos < HDR_BYTES) begin
      if (pos == 32'(POS_CMD)) cmd_byte = b;
      else if (pos == 32'(POS_LEN_LO)) len_field[7:0] = b;
      else if (pos == 32'(POS_LEN_HI)) len_field[15:8] = b;
      crc_acc = crc_ccitt_step(crc_acc, b);
      return;
    end
    pos = pos - HDR_BYTES;
    if (pos < 32'(len_field)) begin
      crc_acc = crc_ccitt_step(crc_acc, b);
      push_result(1'b0, b, pos[8:0], ST_OK);
    end else if (pos == 32'(len_field)) begin
      crc_lo = b;
    end else if (len_field > 16'(regs.max_payload)) begin
      // length is judged before the CRC
      close_frame(ST_LEN);
    end else if (crc_acc == {b, crc_lo}) begin
      close_frame(ST_OK);
    end else begin
      close_frame(ST_CRC);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.sof_byte    = RST_SOF_BYTE;
      regs.max_payload = RST_MAX_PAYLOAD;
      regs.timeout_ms  = RST_TIMEOUT_MS;
      framing     = 1'b0;
      held        = 0;
      cmd_byte    = 8'h00;
      len_field   = 16'h0000;
      crc_acc     = CRC_INIT;
      crc_lo      = 8'h00;
      t_open      = 32'h0;
      good_frames = 32'h0;
      bad_frames  = 32'h0;
      results_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, actual tuser=%b tdata=%h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = results_due.pop_front();
          got.kind          = out_tuser;
          got.payload_byte  = out_tdata[7:0];
          got.payload_index = out_tdata[16:8];
          got.command       = out_tdata[24:17];
          got.frame_len     = out_tdata[40:25];
          got.status        = status_t'(out_tdata[43:41]);
          got.good_count    = out_tdata[75:44];
          got.error_count   = out_tdata[107:76];
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
          check_field("payload_index", 32'(want.payload_index), 32'(got.payload_index));
          check_field("command", 32'(want.command), 32'(got.command));
          check_field("frame_len", 32'(want.frame_len), 32'(got.frame_len));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("good_count", want.good_count, got.good_count);
          check_field("error_count", want.error_count, got.error_count);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SOF_BYTE:    regs.sof_byte    = cfg_wdata[7:0];
          REG_MAX_PAYLOAD: regs.max_payload = cfg_wdata[8:0];
          REG_TIMEOUT_MS:  regs.timeout_ms  = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) framer_step(in_tuser, in_tdata[7:0], in_tdata[39:8]);
    end
    pending = results_due.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top of the packet receiver bench: clock, reset, request and result stream
// drivers, register writes and the verdict. Depends on cpr_pkg, cpr_tb_pkg,
// cpr_checker and crc_checked_packet_receiver_core.
module testbench;
  import cpr_pkg::*;
  import cpr_tb_pkg::*;

  localparam int SETTLE      = 6;    // two-stage pipe plus margin
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_TIMEOUT, FR_CUT, FR_OVERFLOW} frame_kind_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  wire                    in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  wire                    out_tvalid;
  logic                   out_tready;
  wire  [OUT_TDATA_W-1:0] out_tdata;
  wire                    out_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     mismatches;
  int                     pending;

  logic        quiet;      // no idling on either side
  logic        hold_rx;    // asks the result side for one long hold-off
  int          sent;
  int          tx_calm;
  int          rx_calm;
  logic [31:0] ms_now;
  logic [31:0] t0;         // now_ms of the current frame's marker
  logic [7:0]  marker;
  logic [8:0]  max_len;
  logic [15:0] tmo;

  crc_checked_packet_receiver_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  cpr_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** crc_checked_packet_receiver_core: FAILED **");
    $finish;
  end

  // result side: random stall bursts, calm stretches, one long hold on request
  initial begin
    out_tready = 1'b0;
    rx_calm    = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!quiet && rx_calm == 0 && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 50) == 0) rx_calm = $urandom_range(20, 150);
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic tick, input logic [7:0] b, input logic [31:0] now);
    if (!quiet) begin
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(0, 7) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else if ($urandom_range(0, 40) == 0) tx_calm = $urandom_range(20, 120);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= tick;
    in_tdata  <= {now, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    ms_now = ms_now + $urandom_range(0, 3);
    send_item(1'b0, b, ms_now);
  endtask

  // pattern < 0: random payload; otherwise payload alternates pattern and its inverse
  task automatic send_frame(input frame_kind_t how, input logic [7:0] command,
                            input logic [15:0] len, input int pattern);
    logic [15:0] crc;
    logic [15:0] flip;
    logic [31:0] age;
    logic [7:0]  d;
    int          total;
    int          stop_at;
    crc     = CRC_INIT;
    flip    = (how == FR_BAD_CRC) ? (16'h0001 << $urandom_range(0, 15)) : 16'h0000;
    total   = (how == FR_OVERFLOW) ? BUFFER_BYTES + 1 : HDR_BYTES + 2 + len;
    stop_at = $urandom_range(1, total - 1);
    for (int i = 0; i < total; i++) begin
      if (i == 0) d = marker;
      else if (i == 1) d = command;
      else if (i == 2) d = len[7:0];
      else if (i == 3) d = len[15:8];
      else if (i < HDR_BYTES + len) begin
        if (pattern < 0) d = 8'($urandom);
        else d = pattern[7:0] ^ ((i % 2 == 1) ? 8'hFF : 8'h00);
      end else if (i == HDR_BYTES + len) d = crc[7:0] ^ flip[7:0];
      else d = crc[15:8] ^ flip[15:8];
      // the byte that finds the buffer full is a marker: it must be dropped
      if (how == FR_OVERFLOW && i == BUFFER_BYTES) d = marker;
      if (i < HDR_BYTES + len) crc = crc_ccitt_step(crc, d);
      if (how == FR_TIMEOUT && i == stop_at) begin
        send_item(1'b1, 8'($urandom), t0 + tmo + 32'd1 + $urandom_range(0, 5000));
        return;
      end
      if (how == FR_CUT && i == stop_at) return;
      if (i > 0 && $urandom_range(0, 15) == 0) begin
        // tick that must not abort: age at most the timeout, often exactly it
        age = ($urandom_range(0, 3) == 0) ? {16'h0000, tmo} : $urandom_range(0, tmo);
        send_item(1'b1, 8'($urandom), t0 + age);
      end
      send_byte(d);
      if (i == 0) t0 = ms_now;
    end
  endtask

  task automatic run_frames(input int stop_count);
    int          r;
    int          lim;
    logic [15:0] len;
    logic [7:0]  d;
    frame_kind_t how;
    while (sent < stop_count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        d = 8'($urandom);
        if (d == marker) d = ~d;
        send_byte(d);
      end else if (r < 12) begin
        send_item(1'b1, 8'($urandom), $urandom);
      end else begin
        r   = $urandom_range(0, 9);
        lim = (max_len < 9'd10) ? int'(max_len) : 10;
        if (r < 7 || max_len > 9'd502) len = 16'($urandom_range(0, lim));
        else len = 16'($urandom_range(max_len + 1, max_len + 4));
        r = $urandom_range(0, 99);
        if (r < 75) how = FR_GOOD;
        else if (r < 87) how = FR_BAD_CRC;
        else if (r < 96) how = FR_TIMEOUT;
        else how = FR_CUT;
        send_frame(how, 8'($urandom), len, -1);
      end
    end
  endtask

  task automatic wait_idle;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // requests without a result may still sit in the pipe
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] m, input logic [8:0] mx, input logic [15:0] t);
    logic [15:0] junk;
    wait_idle();
    junk = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SOF_BYTE;
    cfg_wdata <= {junk[15:8], m};
    @(posedge clk);
    cfg_index <= REG_MAX_PAYLOAD;
    cfg_wdata <= {junk[6:0], mx};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_MS;
    cfg_wdata <= t;
    @(posedge clk);
    // write to an unused index, must be ignored
    cfg_index <= REG_UNUSED;
    cfg_wdata <= ~junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker  = m;
    max_len = mx;
    tmo     = t;
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    hold_rx   = 1'b0;
    sent      = 0;
    tx_calm   = 0;
    marker    = RST_SOF_BYTE;
    max_len   = RST_MAX_PAYLOAD;
    tmo       = RST_TIMEOUT_MS;
    ms_now    = $urandom;
    t0        = 32'h0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: noise and a tick with no frame open
    send_byte(8'h00);
    send_byte(8'hFF);
    send_item(1'b1, 8'h55, 32'hFFFF_FFFF);
    // good frame, command equal to the marker, payload 00/FF
    send_frame(FR_GOOD, RST_SOF_BYTE, 16'd2, 0);
    send_frame(FR_BAD_CRC, 8'hFF, 16'd0, 0);
    // tick at exactly the timeout keeps the frame, one ms later aborts it
    send_byte(marker);
    t0 = ms_now;
    send_item(1'b1, 8'h00, t0 + tmo);
    send_item(1'b1, 8'hFF, t0 + tmo + 32'd1);

    set_config(RST_SOF_BYTE, RST_MAX_PAYLOAD, RST_TIMEOUT_MS);
    run_frames(sent + 150);

    // every non-empty payload is a length error, every later tick with a nonzero age aborts
    set_config(8'h00, 9'd0, 16'd0);
    run_frames(sent + 150);

    set_config(8'hFF, 9'd506, 16'hFFFF);
    ms_now = 32'hFFFF_FF00;
    run_frames(sent + 40);
    send_frame(FR_OVERFLOW, 8'($urandom), 16'($urandom_range(507, 65535)), -1);
    run_frames(sent + 40);

    set_config(8'($urandom), 9'($urandom_range(0, 20)), 16'($urandom_range(0, 50)));
    hold_rx = 1'b1;
    run_frames(sent + 200);

    set_config(8'($urandom), 9'($urandom_range(0, 506)), 16'($urandom));
    quiet = 1'b1;
    run_frames(sent + 150);

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("** crc_checked_packet_receiver_core: PASSED **");
    end else begin
      $display("** crc_checked_packet_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cpr_pkg.sv
rtl/cpr_in_stage.sv
rtl/cpr_frame_eng.sv
rtl/cpr_out_stage.sv
rtl/crc_checked_packet_receiver_core.sv
test/cpr_tb_pkg.sv
test/cpr_checker.sv
test/testbench.sv
